[sv/skbs_pkg.sv]
package skbs_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned KEY_BYTES_DEF   = 64;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned WORD_IDX_W = 3;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned COUNT_W    = 7;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ISS,
    S_RD_EV,
    S_CMP_ISS,
    S_CMP_EV,
    S_ROT,
    S_POST
  } state_e;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_STEP,
    CH_ROT
  } chain_op_e;

  typedef struct packed {
    chain_op_e op;
    logic      swap;
  } chain_ctl_t;

  typedef struct packed {
    logic decided;
    logic swap;
  } cmp_res_t;

  // Compares one word of the string at the head against the same word of its neighbor.
  // On the first word an empty head always swaps and an empty neighbor never does.
  function automatic cmp_res_t word_cmp(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                        logic first);
    cmp_res_t   res;
    logic [7:0] ca;
    logic [7:0] cb;
    res.decided = 1'b0;
    res.swap    = 1'b0;
    if (first && (a[DATA_W-1 -: 8] == 8'd0)) begin
      res.decided = 1'b1;
      res.swap    = 1'b1;
    end else if (first && (b[DATA_W-1 -: 8] == 8'd0)) begin
      res.decided = 1'b1;
      res.swap    = 1'b0;
    end else begin
      for (int k = 0; k < 8; k++) begin
        ca = a[DATA_W-1-8*k -: 8];
        cb = b[DATA_W-1-8*k -: 8];
        if (!res.decided) begin
          if (ca != cb) begin
            res.decided = 1'b1;
            res.swap    = (ca > cb);
          end else if (ca == 8'd0) begin
            res.decided = 1'b1;
            res.swap    = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

endpackage

[sv/skbs_if.sv]
interface skbs_req_if;
  logic                              valid;
  logic                              ready;
  logic [skbs_pkg::MODE_W-1:0]       mode;
  logic [skbs_pkg::POS_W-1:0]        entry_index;
  logic [skbs_pkg::WORD_IDX_W-1:0]   word_index;
  logic [skbs_pkg::DATA_W-1:0]       data_word;
  logic [skbs_pkg::COUNT_W-1:0]      entry_count;

  modport source (
    output valid, mode, entry_index, word_index, data_word, entry_count,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, word_index, data_word, entry_count,
    output ready
  );
endinterface

interface skbs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [skbs_pkg::DATA_W-1:0] read_word;
  logic                        sort_done;

  modport source (
    output valid, read_word, sort_done,
    input  ready
  );
  modport sink (
    input  valid, read_word, sort_done,
    output ready
  );
endinterface

[sv/skbs_cell.sv]
module skbs_cell #(
  parameter int unsigned SLOT_W    = 6,
  parameter int unsigned INIT_SLOT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skbs_pkg::chain_op_e op_i,
  input  logic [SLOT_W-1:0]   right_i,
  input  logic [SLOT_W-1:0]   step_i,
  output logic [SLOT_W-1:0]   slot_o
);

  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] slot_d;

  always_comb begin
    case (op_i)
      skbs_pkg::CH_STEP: slot_d = step_i;
      skbs_pkg::CH_ROT:  slot_d = right_i;
      default:           slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_W'(INIT_SLOT);
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

[sv/skbs_chain.sv]
module skbs_chain #(
  parameter int unsigned MAX_ENTRIES = skbs_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned SLOT_W      = $clog2(MAX_ENTRIES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skbs_pkg::chain_ctl_t ctl_i,
  input  logic [SLOT_W-1:0]    pick_idx_i,
  output logic [SLOT_W-1:0]    head_o,
  output logic [SLOT_W-1:0]    second_o,
  output logic [SLOT_W-1:0]    pick_o
);

  logic [SLOT_W-1:0] slot   [MAX_ENTRIES];
  logic [SLOT_W-1:0] step_v [MAX_ENTRIES];
  logic [SLOT_W-1:0] keep;
  logic [SLOT_W-1:0] out;

  // A compare step keeps the larger string at the head and sends the other to the tail.
  assign keep = ctl_i.swap ? slot[0] : slot[1];
  assign out  = ctl_i.swap ? slot[1] : slot[0];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam int unsigned RIGHT = (i + 1) % MAX_ENTRIES;
    if (i == 0) begin : g_head
      assign step_v[i] = keep;
    end else if (i == MAX_ENTRIES - 1) begin : g_tail
      assign step_v[i] = out;
    end else begin : g_mid
      assign step_v[i] = slot[RIGHT];
    end
    skbs_cell #(
      .SLOT_W    (SLOT_W),
      .INIT_SLOT (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (ctl_i.op),
      .right_i (slot[RIGHT]),
      .step_i  (step_v[i]),
      .slot_o  (slot[i])
    );
  end

  assign head_o   = slot[0];
  assign second_o = slot[1];
  assign pick_o   = slot[pick_idx_i];

endmodule

[sv/string_key_bubble_sorter.sv]
// A load leaves the block idle, so the next item is accepted in the following cycle.
// A read of word w makes one key store read per word, from word 0 up to w, before its answer is posted.
// A sort compare reads one word pair per cycle from the two key store read ports until decided or the
// last word is read; a pass adds MAX_ENTRIES minus its compares in chain rotations.
// Reset sets the position chain to the identity order; the key store is not cleared.
// A new item is taken only when the previous one has finished its work.
module string_key_bubble_sorter #(
  parameter int unsigned MAX_ENTRIES = skbs_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KEY_BYTES   = skbs_pkg::KEY_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  skbs_req_if.sink       req_i,
  skbs_rsp_if.source     rsp_o
);

  localparam int unsigned SLOT_W    = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_WORDS = (KEY_BYTES + 7) / 8;
  localparam int unsigned WORD_W    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned ADDR_W    = SLOT_W + WORD_W;
  localparam int unsigned MEM_DEPTH = 2 ** ADDR_W;
  localparam int unsigned DATA_W    = skbs_pkg::DATA_W;

  skbs_pkg::state_e     state_q, state_d;
  skbs_pkg::chain_ctl_t chain_ctl;
  skbs_pkg::cmp_res_t   cmp;

  logic [WORD_W-1:0] wk_q, wk_d;
  logic              term_q, term_d;
  logic [CNT_W-1:0]  m_q, m_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [CNT_W-1:0]  rot_q, rot_d;
  logic              swapped_q, swapped_d;
  logic              out_vld_q, out_vld_d;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WORD_W-1:0] tgt_q, tgt_d;
  logic [DATA_W-1:0] res_word_q, res_word_d;
  logic              res_done_q, res_done_d;
  logic [DATA_W-1:0] out_word_q;
  logic              out_done_q;

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_a_q, rdata_b_q;
  logic [ADDR_W-1:0] addr_a, addr_b, waddr;
  logic              we;

  logic              accept;
  logic [31:0]       pos_wide, word_wide, cnt_wide, cnt_sat, byte_base;
  logic              pos_ok, word_ok;
  logic [SLOT_W-1:0] pick_idx, pick_slot, head_slot, second_slot;
  logic [WORD_W-1:0] word_sel;
  logic [CNT_W-1:0]  n_cnt;
  logic [DATA_W-1:0] a_m, b_m, rd_word;
  logic [7:0]        zero_b;
  logic              seen_zero;
  logic              last_word;
  logic              out_load;

  assign accept    = req_i.valid && req_i.ready;
  assign pos_wide  = 32'(req_i.entry_index);
  assign word_wide = 32'(req_i.word_index);
  assign cnt_wide  = 32'(req_i.entry_count);
  assign pos_ok    = pos_wide < MAX_ENTRIES;
  assign word_ok   = word_wide < KEY_WORDS;
  assign pick_idx  = pos_wide[SLOT_W-1:0];
  assign word_sel  = word_wide[WORD_W-1:0];
  assign cnt_sat   = (cnt_wide > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : cnt_wide;
  assign n_cnt     = cnt_sat[CNT_W-1:0];
  assign last_word = (32'(wk_q) == KEY_WORDS - 1);
  assign byte_base = 32'(wk_q) << 3;

  skbs_chain #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SLOT_W      (SLOT_W)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (chain_ctl),
    .pick_idx_i (pick_idx),
    .head_o     (head_slot),
    .second_o   (second_slot),
    .pick_o     (pick_slot)
  );

  // Bytes past the key length read as zero, so they also end the string.
  always_comb begin
    a_m       = '0;
    b_m       = '0;
    rd_word   = '0;
    seen_zero = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if ((byte_base + 32'(k)) < KEY_BYTES) begin
        a_m[DATA_W-1-8*k -: 8] = rdata_a_q[DATA_W-1-8*k -: 8];
        b_m[DATA_W-1-8*k -: 8] = rdata_b_q[DATA_W-1-8*k -: 8];
      end
    end
    for (int k = 0; k < 8; k++) begin
      zero_b[k] = (a_m[DATA_W-1-8*k -: 8] == 8'd0);
      if (!seen_zero) begin
        rd_word[DATA_W-1-8*k -: 8] = a_m[DATA_W-1-8*k -: 8];
      end
      seen_zero = seen_zero | zero_b[k];
    end
  end

  assign cmp = skbs_pkg::word_cmp(a_m, b_m, wk_q == '0);

  always_comb begin
    state_d        = state_q;
    wk_d           = wk_q;
    term_d         = term_q;
    m_d            = m_q;
    left_d         = left_q;
    rot_d          = rot_q;
    swapped_d      = swapped_q;
    slot_d         = slot_q;
    tgt_d          = tgt_q;
    res_word_d     = res_word_q;
    res_done_d     = res_done_q;
    chain_ctl.op   = skbs_pkg::CH_HOLD;
    chain_ctl.swap = 1'b0;
    addr_a         = {slot_q, wk_q};
    addr_b         = {slot_q, wk_q};
    waddr          = {pick_slot, word_sel};
    we             = 1'b0;
    out_load       = 1'b0;
    req_i.ready    = (state_q == skbs_pkg::S_IDLE);

    case (state_q)
      skbs_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            skbs_pkg::MODE_LOAD: begin
              we = pos_ok && word_ok;
            end
            skbs_pkg::MODE_SORT: begin
              if (n_cnt < CNT_W'(2)) begin
                res_word_d = '0;
                res_done_d = 1'b1;
                state_d    = skbs_pkg::S_POST;
              end else begin
                m_d       = n_cnt - CNT_W'(1);
                left_d    = n_cnt - CNT_W'(1);
                swapped_d = 1'b0;
                state_d   = skbs_pkg::S_CMP_ISS;
              end
            end
            skbs_pkg::MODE_READ: begin
              if (pos_ok && word_ok) begin
                slot_d  = pick_slot;
                tgt_d   = word_sel;
                term_d  = 1'b0;
                state_d = skbs_pkg::S_RD_ISS;
              end else begin
                res_word_d = '0;
                res_done_d = 1'b0;
                state_d    = skbs_pkg::S_POST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      skbs_pkg::S_RD_ISS: begin
        addr_a  = {slot_q, WORD_W'(0)};
        wk_d    = '0;
        state_d = skbs_pkg::S_RD_EV;
      end
      skbs_pkg::S_RD_EV: begin
        if (wk_q == tgt_q) begin
          res_word_d = term_q ? '0 : rd_word;
          res_done_d = 1'b0;
          state_d    = skbs_pkg::S_POST;
        end else begin
          term_d = term_q | (|zero_b);
          wk_d   = wk_q + WORD_W'(1);
          addr_a = {slot_q, wk_q + WORD_W'(1)};
        end
      end
      skbs_pkg::S_CMP_ISS: begin
        addr_a  = {head_slot, WORD_W'(0)};
        addr_b  = {second_slot, WORD_W'(0)};
        wk_d    = '0;
        state_d = skbs_pkg::S_CMP_EV;
      end
      skbs_pkg::S_CMP_EV: begin
        if (cmp.decided || last_word) begin
          chain_ctl.op   = skbs_pkg::CH_STEP;
          chain_ctl.swap = cmp.decided && cmp.swap;
          swapped_d      = swapped_q | chain_ctl.swap;
          left_d         = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            rot_d   = CNT_W'(MAX_ENTRIES) - m_q;
            state_d = skbs_pkg::S_ROT;
          end else begin
            state_d = skbs_pkg::S_CMP_ISS;
          end
        end else begin
          wk_d   = wk_q + WORD_W'(1);
          addr_a = {head_slot, wk_q + WORD_W'(1)};
          addr_b = {second_slot, wk_q + WORD_W'(1)};
        end
      end
      skbs_pkg::S_ROT: begin
        chain_ctl.op = skbs_pkg::CH_ROT;
        rot_d        = rot_q - CNT_W'(1);
        if (rot_q == CNT_W'(1)) begin
          if (!swapped_q || (m_q == CNT_W'(1))) begin
            res_word_d = '0;
            res_done_d = 1'b1;
            state_d    = skbs_pkg::S_POST;
          end else begin
            m_d       = m_q - CNT_W'(1);
            left_d    = m_q - CNT_W'(1);
            swapped_d = 1'b0;
            state_d   = skbs_pkg::S_CMP_ISS;
          end
        end
      end
      skbs_pkg::S_POST: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = skbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skbs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= skbs_pkg::S_IDLE;
      wk_q      <= '0;
      term_q    <= 1'b0;
      m_q       <= '0;
      left_q    <= '0;
      rot_q     <= '0;
      swapped_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wk_q      <= wk_d;
      term_q    <= term_d;
      m_q       <= m_d;
      left_q    <= left_d;
      rot_q     <= rot_d;
      swapped_q <= swapped_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    tgt_q      <= tgt_d;
    res_word_q <= res_word_d;
    res_done_q <= res_done_d;
    if (out_load) begin
      out_word_q <= res_word_q;
      out_done_q <= res_done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= req_i.data_word;
    end
    rdata_a_q <= mem[addr_a];
    rdata_b_q <= mem[addr_b];
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.read_word = out_word_q;
  assign rsp_o.sort_done = out_done_q;

`ifndef NO_ASSERTIONS
  a_rot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skbs_pkg::S_ROT) |-> (rot_q != '0))
    else $error("Rotation entered with no steps left.");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skbs_pkg::S_CMP_ISS) |-> ((left_q != '0) && (left_q <= m_q)))
    else $error("Compare count of the pass is out of bounds.");

  a_early_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skbs_pkg::S_ROT && rot_q == CNT_W'(1) && !swapped_q)
      |=> (state_q == skbs_pkg::S_POST))
    else $error("A pass without swaps did not end the sort.");

  a_post_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skbs_pkg::S_POST && (!out_vld_q || rsp_o.ready)) |=> out_vld_q)
    else $error("A finished result was not placed in the output register.");
`endif

endmodule

[tb/skbs_order_checker.sv]
`timescale 1ns / 100ps

module skbs_order_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  skbs_req_if         req_mon,
  skbs_rsp_if         rsp_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned answers_due_o
);

  localparam int unsigned MAX_ENTRIES  = skbs_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned KEY_BYTES    = skbs_pkg::KEY_BYTES_DEF;
  localparam int unsigned KEY_WORDS    = (KEY_BYTES + 7) / 8;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [skbs_pkg::DATA_W-1:0] read_word;
    logic                        sort_done;
  } answer_t;

  logic [skbs_pkg::DATA_W-1:0] key_mem [MAX_ENTRIES*KEY_WORDS];
  logic [skbs_pkg::POS_W-1:0]  slot_of [MAX_ENTRIES];
  answer_t                     pending_answers [$];

  function automatic logic [7:0] key_byte(input int unsigned slot, input int unsigned b);
    logic [skbs_pkg::DATA_W-1:0] w;
    if (b >= KEY_BYTES) begin
      return 8'h00;
    end
    w = key_mem[slot * KEY_WORDS + b / 8];
    return w[skbs_pkg::DATA_W-1-8*(b%8) -: 8];
  endfunction

  function automatic int unsigned key_length(input int unsigned slot);
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (key_byte(slot, b) == 8'h00) begin
        return b;
      end
    end
    return KEY_BYTES;
  endfunction

  function automatic bit orders_after(input int unsigned a, input int unsigned b);
    logic [7:0] ca;
    logic [7:0] cb;
    for (int k = 0; k < KEY_BYTES; k++) begin
      ca = key_byte(a, k);
      cb = key_byte(b, k);
      if (ca != cb) begin
        return ca > cb;
      end
      if (ca == 8'h00) begin
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // Empty keys sink to the end: a pair whose first key is empty always swaps.
  function automatic void bubble_sort(input int n);
    bit                         swapped;
    bit                         a_empty;
    bit                         b_empty;
    logic [skbs_pkg::POS_W-1:0] sa;
    logic [skbs_pkg::POS_W-1:0] sb;
    if (n < 2) begin
      return;
    end
    for (int i = 0; i < n - 1; i++) begin
      swapped = 1'b0;
      for (int j = 0; j < n - 1 - i; j++) begin
        sa      = slot_of[j];
        sb      = slot_of[j+1];
        a_empty = key_byte(sa, 0) == 8'h00;
        b_empty = key_byte(sb, 0) == 8'h00;
        if (a_empty || (!b_empty && orders_after(sa, sb))) begin
          slot_of[j]   = sb;
          slot_of[j+1] = sa;
          swapped      = 1'b1;
        end
      end
      if (!swapped) begin
        break;
      end
    end
  endfunction

  function automatic logic [skbs_pkg::DATA_W-1:0] masked_word(input int unsigned pos,
                                                             input int unsigned word);
    logic [skbs_pkg::DATA_W-1:0] r;
    int unsigned                 slot;
    int unsigned                 len;
    r    = '0;
    slot = slot_of[pos];
    len  = key_length(slot);
    for (int k = 0; k < 8; k++) begin
      if (word * 8 + k < len) begin
        r[skbs_pkg::DATA_W-1-8*k -: 8] = key_byte(slot, word * 8 + k);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got;
    answer_t due;
    int      n;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_of[i] = i[skbs_pkg::POS_W-1:0];
      end
      for (int i = 0; i < MAX_ENTRIES * KEY_WORDS; i++) begin
        key_mem[i] = '0;
      end
      pending_answers.delete();
      mismatch_cnt_o = 0;
      answers_due_o  = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.read_word = rsp_mon.read_word;
        got.sort_done = rsp_mon.sort_done;
        if (pending_answers.size() == 0) begin
          if (mismatch_cnt_o < REPORT_LIMIT) begin
            $display("%0t: answer with nothing pending: read_word %h sort_done %b",
                     $realtime, got.read_word, got.sort_done);
          end
          mismatch_cnt_o++;
        end else begin
          due = pending_answers.pop_front();
          if ((got.read_word !== due.read_word) || (got.sort_done !== due.sort_done)) begin
            if (mismatch_cnt_o < REPORT_LIMIT) begin
              $display("%0t: answer mismatch: expected read_word %h sort_done %b,",
                       $realtime, due.read_word, due.sort_done);
              $display("    got read_word %h sort_done %b", got.read_word, got.sort_done);
            end
            mismatch_cnt_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.mode)
          skbs_pkg::MODE_LOAD: begin
            key_mem[slot_of[req_mon.entry_index] * KEY_WORDS + req_mon.word_index] =
              req_mon.data_word;
          end
          skbs_pkg::MODE_SORT: begin
            n = (req_mon.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : req_mon.entry_count;
            bubble_sort(n);
            due.read_word = '0;
            due.sort_done = 1'b1;
            pending_answers.push_back(due);
          end
          skbs_pkg::MODE_READ: begin
            due.read_word = masked_word(req_mon.entry_index, req_mon.word_index);
            due.sort_done = 1'b0;
            pending_answers.push_back(due);
          end
          default: begin
          end
        endcase
      end
      answers_due_o = pending_answers.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam logic [skbs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned KEY_WORDS    = (skbs_pkg::KEY_BYTES_DEF + 7) / 8;
  localparam int unsigned KEY_BITS     = KEY_WORDS * skbs_pkg::DATA_W;
  localparam int unsigned LAST_POS     = skbs_pkg::MAX_ENTRIES_DEF - 1;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 770;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned items_sent = 0;
  int unsigned mismatches;
  int unsigned answers_due;

  skbs_req_if req_if ();
  skbs_rsp_if rsp_if ();

  string_key_bubble_sorter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  skbs_order_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .mismatch_cnt_o (mismatches),
    .answers_due_o  (answers_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : answer_sink
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != holds_served) begin
        holds_served = hold_asks;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  function automatic logic [skbs_pkg::DATA_W-1:0] noise_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_BITS-1:0] noise_key();
    logic [KEY_BITS-1:0] k;
    for (int w = 0; w < KEY_BITS / 32; w++) begin
      k[32*w +: 32] = $urandom();
    end
    return k;
  endfunction

  // Short keys over a tiny alphabet give many ties and shared prefixes.
  function automatic logic [KEY_BITS-1:0] random_key();
    logic [KEY_BITS-1:0] k;
    int unsigned         pick;
    int unsigned         len;
    k    = noise_key();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len = 0;
    end else if (pick < 18) begin
      len = KEY_BITS / 8;
    end else if (pick < 60) begin
      len = $urandom_range(1, 6);
    end else begin
      len = $urandom_range(1, KEY_BITS / 8 - 1);
    end
    for (int b = 0; b < len; b++) begin
      k[KEY_BITS-1-8*b -: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
                                                            8'($urandom_range(8'h61, 8'h63));
    end
    if (len < KEY_BITS / 8) begin
      k[KEY_BITS-1-8*len -: 8] = 8'h00;
    end
    return k;
  endfunction

  function automatic logic [KEY_BITS-1:0] special_key(input int unsigned p);
    logic [KEY_BITS-1:0] k;
    k = noise_key();
    case (p)
      0: k = '0;
      1: k[KEY_BITS-1 -: 8] = 8'h00;
      2: k = '1;
      3: k[KEY_BITS-1 -: 16] = 16'h0100;
      4, 5: k[KEY_BITS-1 -: 24] = 24'h414200;
      6: k[KEY_BITS-1 -: 16] = 16'h4100;
      default: k = {{(KEY_BITS / 8 - 1){8'h7a}}, 8'h00};
    endcase
    return k;
  endfunction

  function automatic int unsigned pick_pos();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, LAST_POS) : $urandom_range(0, 15);
  endfunction

  task automatic send_item(input logic [skbs_pkg::MODE_W-1:0] mode,
                           input int unsigned pos, input int unsigned word,
                           input logic [skbs_pkg::DATA_W-1:0] data,
                           input int unsigned count);
    while (!quiet && ($urandom_range(0, 99) < 15)) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.entry_index <= pos[skbs_pkg::POS_W-1:0];
    req_if.word_index  <= word[skbs_pkg::WORD_IDX_W-1:0];
    req_if.data_word   <= data;
    req_if.entry_count <= count[skbs_pkg::COUNT_W-1:0];
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    if (mode != MODE_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic store_key(input int unsigned pos, input logic [KEY_BITS-1:0] key);
    for (int w = 0; w < KEY_WORDS; w++) begin
      send_item(skbs_pkg::MODE_LOAD, pos, w, key[KEY_BITS-1-skbs_pkg::DATA_W*w -: 64],
                $urandom_range(0, 127));
    end
  endtask

  task automatic send_read(input int unsigned pos, input int unsigned word);
    send_item(skbs_pkg::MODE_READ, pos, word, noise_word(), $urandom_range(0, 127));
  endtask

  initial begin : stimulus
    logic [KEY_BITS-1:0] key;
    int unsigned         pick;
    int unsigned         n;
    int unsigned         next_hold;
    req_if.valid       = 1'b0;
    req_if.mode        = skbs_pkg::MODE_LOAD;
    req_if.entry_index = '0;
    req_if.word_index  = '0;
    req_if.data_word   = '0;
    req_if.entry_count = '0;
    rst_ni             = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every entry is written in full before any read or sort touches it.
    for (int p = 0; p <= LAST_POS; p++) begin
      store_key(p, (p < 8) ? special_key(p) : random_key());
    end

    send_read(2, KEY_WORDS - 1);
    send_read(7, KEY_WORDS - 1);
    send_read(4, 0);
    send_item(MODE_UNUSED, LAST_POS, KEY_WORDS - 1, '1, 127);
    send_item(skbs_pkg::MODE_SORT, 0, 0, '0, 0);
    send_item(skbs_pkg::MODE_SORT, 0, 0, '0, 1);
    send_item(skbs_pkg::MODE_SORT, 0, 0, '0, 8);
    for (int p = 0; p < 8; p++) begin
      send_read(p, 0);
    end
    send_read(6, KEY_WORDS - 1);
    send_item(skbs_pkg::MODE_SORT, 0, 0, '0, 127);
    send_item(skbs_pkg::MODE_SORT, 0, 0, '0, skbs_pkg::MAX_ENTRIES_DEF);
    send_item(skbs_pkg::MODE_LOAD, LAST_POS, KEY_WORDS - 1, '0, 0);
    send_read(LAST_POS, KEY_WORDS - 1);
    send_read(0, 0);

    items_sent = 0;
    next_hold  = 200;
    while (items_sent < RANDOM_ITEMS) begin
      quiet <= (items_sent >= 400) && (items_sent < 700);
      if (items_sent >= next_hold) begin
        next_hold += 800;
        hold_asks <= hold_asks + 1;
        repeat (12) send_read(pick_pos(), $urandom_range(0, KEY_WORDS - 1));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          store_key(pick_pos(), random_key());
        end else if (pick < 35) begin
          key = random_key();
          send_item(skbs_pkg::MODE_LOAD, pick_pos(), $urandom_range(0, KEY_WORDS - 1),
                    $urandom_range(0, 1) ? noise_word() : key[KEY_BITS-1 -: 64],
                    $urandom_range(0, 127));
        end else if (pick < 43) begin
          pick = $urandom_range(0, 99);
          if (pick < 80) begin
            n = $urandom_range(0, 12);
          end else if (pick < 92) begin
            n = $urandom_range(13, 40);
          end else begin
            n = $urandom_range(41, 127);
          end
          send_item(skbs_pkg::MODE_SORT, $urandom_range(0, LAST_POS),
                    $urandom_range(0, KEY_WORDS - 1), noise_word(), n);
          for (int p = 0; p < n && p < 16; p++) begin
            send_read(p, $urandom_range(0, 1) ? 0 : $urandom_range(0, KEY_WORDS - 1));
          end
        end else if (pick < 46) begin
          send_item(MODE_UNUSED, $urandom_range(0, LAST_POS), $urandom_range(0, KEY_WORDS - 1),
                    noise_word(), $urandom_range(0, 127));
        end else begin
          repeat ($urandom_range(1, 4)) send_read(pick_pos(), $urandom_range(0, KEY_WORDS - 1));
        end
      end
    end
    req_if.valid <= 1'b0;

    wait (answers_due == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
